>>> design/cdq_pkg.sv
// cdq_pkg: command and status codes plus control types for the circular deque.
// No dependencies; used by cdq_ctrl and circular_deque.
package cdq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL_PUSH  = 2'd1,
        ST_EMPTY_POP  = 2'd2
    } t_status;

    // Slot memory strobes issued by the controller.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

>>> design/circular_deque.sv
// circular_deque: double-ended queue in a ring of DEPTH slots, DEPTH-1 usable.
// Depends on cdq_pkg, cdq_ctrl and cdq_mem.
//
//  channel  valid        ready        payload
//  in       i_in_valid   o_in_ready   i_cmd, i_push_value
//  out      o_out_valid  i_out_ready  o_status, o_pop_value, o_now_empty, o_now_full
//
// An item's result appears in the cycle after it is taken, the popped
// word coming from the slot memory's registered read port. With the result
// taken at once, one item is accepted every cycle. While a result waits,
// o_in_ready follows i_out_ready. Reset zeroes both ring pointers; slot
// contents are not cleared and need no clearing pass.
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [DATA_WIDTH-1:0] i_push_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [DATA_WIDTH-1:0] o_pop_value,
    output logic                  o_now_empty,
    output logic                  o_now_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cdq_pkg::t_mem_ctl     mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  pop_sel;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_pop_sel   (pop_sel),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    cdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_ctl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (mem_ctl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Drop the read word unless the item was a successful pop.
    assign o_pop_value = pop_sel ? rd_data : '0;

endmodule

>>> design/cdq_mem.sv
// cdq_mem: slot storage of the deque, one write port and one registered read port.
// Depends on nothing; instantiated by circular_deque.
module cdq_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/cdq_ctrl.sv
// cdq_ctrl: ring pointers, command decode, full/empty checks and the result register.
// Depends on cdq_pkg; drives the strobes and addresses of cdq_mem.
module cdq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    output cdq_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_pop_sel,
    output logic              o_now_empty,
    output logic              o_now_full
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
        ring_prev = (idx == '0) ? LAST : idx - 1'b1;
    endfunction

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic             r_out_valid;
    cdq_pkg::t_status r_status, n_status;
    logic             r_pop_sel, n_pop_sel;
    logic             r_now_empty, r_now_full;
    logic             accept;
    logic             cur_empty, cur_full;
    logic [AW-1:0]    head_nx, head_pv, tail_nx, tail_pv;
    cdq_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]    wr_addr, rd_addr;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign head_nx   = ring_next(r_head);
    assign head_pv   = ring_prev(r_head);
    assign tail_nx   = ring_next(r_tail);
    assign tail_pv   = ring_prev(r_tail);
    assign cur_empty = (r_head == r_tail);
    assign cur_full  = (tail_nx == r_head);

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_status       = cdq_pkg::ST_DONE;
        n_pop_sel      = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        wr_addr        = r_head;
        rd_addr        = r_tail;
        unique case (cdq_pkg::t_cmd'(i_cmd))
            cdq_pkg::CMD_PUSH_FRONT: begin
                if (cur_full) begin
                    n_status = cdq_pkg::ST_FULL_PUSH;
                end else begin
                    mem_ctl.wr_en = accept;
                    wr_addr       = r_head;
                    n_head        = head_pv;
                end
            end
            cdq_pkg::CMD_PUSH_BACK: begin
                if (cur_full) begin
                    n_status = cdq_pkg::ST_FULL_PUSH;
                end else begin
                    mem_ctl.wr_en = accept;
                    wr_addr       = tail_nx;
                    n_tail        = tail_nx;
                end
            end
            cdq_pkg::CMD_POP_FRONT: begin
                if (cur_empty) begin
                    n_status = cdq_pkg::ST_EMPTY_POP;
                end else begin
                    mem_ctl.rd_en = accept;
                    rd_addr       = head_nx;
                    n_head        = head_nx;
                    n_pop_sel     = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_BACK: begin
                if (cur_empty) begin
                    n_status = cdq_pkg::ST_EMPTY_POP;
                end else begin
                    mem_ctl.rd_en = accept;
                    rd_addr       = r_tail;
                    n_tail        = tail_pv;
                    n_pop_sel     = 1'b1;
                end
            end
            default: begin
                n_status = cdq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields; hold while the result waits downstream.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_pop_sel   <= n_pop_sel;
            r_now_empty <= (n_head == n_tail);
            r_now_full  <= (ring_next(n_tail) == n_head);
        end
    end

    assign o_mem_ctl   = mem_ctl;
    assign o_wr_addr   = wr_addr;
    assign o_rd_addr   = rd_addr;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_sel   = r_pop_sel;
    assign o_now_empty = r_now_empty;
    assign o_now_full  = r_now_full;

endmodule
